### rtl/ppg_heart_rate_spo2_estimator_unit_assert.svh
// Assertion macros shared by the estimator RTL.
`ifndef PPG_HEART_RATE_SPO2_ESTIMATOR_UNIT_ASSERT_SVH
`define PPG_HEART_RATE_SPO2_ESTIMATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define PPG_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define PPG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PPG_ASSERT_IMPL(lbl, ante, cons, msg)
`define PPG_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/ppg_hrs_pkg.sv
package ppg_hrs_pkg;

  localparam int WINDOW_DEPTH_DEF = 100;
  localparam int SAMPLE_BITS_DEF  = 18;

  localparam int RATE_W    = 16;
  localparam int SAT_W     = 15;
  localparam int QUOT_BITS = 16;

  localparam int THRESH_RST    = 30000;
  localparam int RATE_HIST_RST = 19200;
  localparam int SAT_RST       = 24320;

  localparam int PEAK_SKIP = 10;
  localparam int GAP_MIN   = 25;
  localparam int GAP_MAX   = 150;

  // 60 s * 100 Hz * 256 (Q8.8)
  localparam int HR_NUM_K  = 1536000;
  localparam int HR_LOW    = 10240;
  localparam int HR_HIGH   = 35840;
  localparam int CAP_ADD   = 30720;
  localparam int CAP_MUL   = 19;
  localparam int CAP_DIV   = 20;
  localparam int AVG_DIV   = 5;

  localparam int SAT_MUL   = 9;
  localparam int SAT_DIV   = 10;
  localparam int SAT_MAX   = 25600;
  localparam int SAT_MIN   = 17920;
  localparam int SAT_BASE  = 26624;
  localparam int R_SLOPE   = 17;

  // Floor division by 5 as a multiply by ceil(2**22 / 5) and a shift; it is
  // exact for every numerator below 2**22.
  localparam int DIV5_MUL   = 838861;
  localparam int DIV5_SHIFT = 22;
  // Width of a smoothing numerator after its power-of-two prescale.
  localparam int AVG_W      = 19;

endpackage

### rtl/ppg_hrs_ram.sv
module ppg_hrs_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 100
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/ppg_hrs_div.sv
module ppg_hrs_div #(
  parameter int DIVIDEND_W = 45,
  parameter int DIVISOR_W  = 37,
  parameter int QUOT_W     = ppg_hrs_pkg::QUOT_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [QUOT_W-1:0]     quotient
);
  import ppg_hrs_pkg::*;

  // The quotient must fit in QUOT_W bits; the caller guarantees it.
  localparam int CMP_W = DIVISOR_W + QUOT_W;
  localparam int CNT_W = $clog2(QUOT_W + 1);

  logic [DIVIDEND_W-1:0] rem_r;
  logic [CMP_W-1:0]      dsh_r;
  logic [QUOT_W-1:0]     quo_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  done_r;
  logic [CMP_W-1:0]      rem_ext;
  logic                  ge;

  assign rem_ext = CMP_W'(rem_r);
  assign ge      = rem_ext >= dsh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNT_W'(QUOT_W);
      end else if (cnt_r != '0) begin
        cnt_r  <= cnt_r - 1'b1;
        done_r <= cnt_r == CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend;
      dsh_r <= CMP_W'(divisor) << (QUOT_W - 1);
      quo_r <= '0;
    end else if (cnt_r != '0) begin
      if (ge) begin
        rem_r <= DIVIDEND_W'(rem_ext - dsh_r);
      end
      dsh_r <= dsh_r >> 1;
      quo_r <= {quo_r[QUOT_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### rtl/ppg_heart_rate_spo2_estimator_unit.sv
// A request taken with no finger or while the window is filling goes straight to the
// output stage; once the window is full the result follows two passes over the
// window memory plus up to two 16-step divisions. A stall at the output holds it.
// One request at a time; the next is taken once the result is in the output register.
// Reset (synchronous, rst_n low): window empty, rate 0, rate history 75 bpm,
// SpO2 95 percent, finger threshold 30000; window contents stay undefined.
`include "ppg_heart_rate_spo2_estimator_unit_assert.svh"
module ppg_heart_rate_spo2_estimator_unit #(
  parameter int WINDOW_DEPTH = ppg_hrs_pkg::WINDOW_DEPTH_DEF,
  parameter int SAMPLE_BITS  = ppg_hrs_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [SAMPLE_BITS-1:0]         in_red_sample,
  input  logic [SAMPLE_BITS-1:0]         in_ir_sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ppg_hrs_pkg::RATE_W-1:0] out_heart_rate_q8,
  output logic [ppg_hrs_pkg::SAT_W-1:0]  out_spo2_q8,
  output logic                           out_window_full,
  output logic                           out_finger_present,
  input  logic                           cfg_wr_en,
  input  logic [SAMPLE_BITS-1:0]         cfg_wr_data
);
  import ppg_hrs_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int TW = SB + 4;            // ten times a sample
  localparam int PW = 2 * SB + 1;        // ratio-of-ratios products
  localparam int DW = PW + 8;            // divider dividend
  localparam int SW = PW + QUOT_BITS;    // saturation compare
  localparam int MW = 2 * SB;            // memory word: {red, ir}
  localparam int QW = AVG_W + 20;        // divide-by-5 product

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_P1   = 4'd1;   // min/max pass
  localparam logic [3:0] S_THR  = 4'd2;   // peak threshold
  localparam logic [3:0] S_P2   = 4'd3;   // peak pass
  localparam logic [3:0] S_HR   = 4'd4;   // start beat division
  localparam logic [3:0] S_HRD  = 4'd5;   // wait beat rate, set up smoothing
  localparam logic [3:0] S_RD   = 4'd6;   // smoothed rate
  localparam logic [3:0] S_SAT  = 4'd7;   // ratio products
  localparam logic [3:0] S_SM   = 4'd8;   // saturate or divide
  localparam logic [3:0] S_SD   = 4'd9;   // wait ratio
  localparam logic [3:0] S_ST   = 4'd10;  // clamp and set up SpO2 smoothing
  localparam logic [3:0] S_SSD  = 4'd11;  // smoothed SpO2
  localparam logic [3:0] S_OUT  = 4'd12;  // hand result to output register

  logic [3:0]        state_r;
  logic [CW-1:0]     cnt_r;
  logic              rd_vld_r;
  logic [3:0]        skip_r;
  logic              have_last_r;
  logic [AW-1:0]     last_r;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     total_r;
  logic              mode_avg_r;
  logic [AW-1:0]     write_slot_r;
  logic              filled_r;
  logic [RATE_W-1:0] rate_shown_r;
  logic [RATE_W-1:0] rate_hist_r;
  logic [SAT_W-1:0]  sat_r;
  logic [SB-1:0]     thresh_r;
  logic              fin_r;
  logic              full_r;
  logic              out_valid_r;

  logic [SB-1:0]     imax_r, imin_r, rmax_r, rmin_r;
  logic [TW-1:0]     thr10_r;
  logic [SB-1:0]     v1_r, v2_r;
  logic [PW-1:0]     num_r, den_r;
  logic [QUOT_BITS-1:0] r_r;
  logic [AVG_W-1:0]  avg_arg_r;
  logic [RATE_W-1:0] out_rate_r;
  logic [SAT_W-1:0]  out_sat_r;
  logic              out_full_r;
  logic              out_fin_r;

  logic              in_acc;
  logic              finger;
  logic              slot_wrap;
  logic              filled_nxt;
  logic [AW-1:0]     write_slot_nxt;
  logic              out_free;

  logic              mem_we;
  logic              mem_re;
  logic [MW-1:0]     mem_rdata;
  logic [SB-1:0]     rd_red, rd_ir;

  logic              cand_en;
  logic              eval_en;
  logic [CW-1:0]     cand;
  logic [AW-1:0]     cand_i;
  logic [TW-1:0]     v10;
  logic              is_peak;
  logic [AW-1:0]     gap;
  logic              gap_ok;

  logic              div_start;
  logic [DW-1:0]     div_dividend;
  logic [PW-1:0]     div_divisor;
  logic              div_done;
  logic [QUOT_BITS-1:0] div_quo;

  logic              h_band;
  logic              h_high;
  logic              sat_ok;
  logic              sat_over;
  logic [20:0]       m17;
  logic [SAT_W-1:0]  t_val;
  logic [QW-1:0]     q5_prod;
  logic [RATE_W-1:0] q5;

  assign in_ready = state_r == S_IDLE;
  assign in_acc   = in_valid && in_ready;
  assign finger   = in_ir_sample >= thresh_r;
  assign out_free = !out_valid_r || out_ready;

  assign slot_wrap      = 32'(write_slot_r) == WINDOW_DEPTH - 1;
  assign filled_nxt     = filled_r || slot_wrap;
  assign write_slot_nxt = slot_wrap ? '0 : write_slot_r + 1'b1;

  // The window memory holds {red, ir}. It is written only when a request is
  // taken, and read only during the two passes, so accesses never overlap.
  assign mem_we = in_acc && finger;
  assign mem_re = (state_r == S_P1 || state_r == S_P2) && cnt_r < CW'(WINDOW_DEPTH);

  ppg_hrs_ram #(
    .WIDTH(MW),
    .DEPTH(WINDOW_DEPTH)
  ) u_window (
    .clk  (clk),
    .we   (mem_we),
    .waddr(write_slot_r),
    .wdata({in_red_sample, in_ir_sample}),
    .re   (mem_re),
    .raddr(cnt_r[AW-1:0]),
    .rdata(mem_rdata)
  );

  assign rd_red = mem_rdata[MW-1:SB];
  assign rd_ir  = mem_rdata[SB-1:0];

  // Peak pass: data arriving now is slot cnt_r-1, so the slot judged is
  // cnt_r-2, held in v1_r with its left neighbor in v2_r.
  assign cand    = cnt_r - CW'(2);
  assign cand_i  = cand[AW-1:0];
  assign cand_en = state_r == S_P2 && rd_vld_r && cnt_r >= CW'(3);
  assign eval_en = cand_en && skip_r == 4'd0;
  assign v10     = TW'(v1_r) * TW'(10);
  assign is_peak = eval_en && v10 > thr10_r && v1_r > v2_r && v1_r > rd_ir;
  assign gap     = cand_i - last_r;
  assign gap_ok  = have_last_r && 32'(gap) > GAP_MIN && 32'(gap) < GAP_MAX;

  assign h_band = 32'(div_quo) >= HR_LOW && 32'(div_quo) <= HR_HIGH;
  assign h_high = 32'(div_quo) > HR_HIGH;

  assign sat_ok   = imax_r != '0 && rmax_r != '0 && imax_r != imin_r;
  assign sat_over = SW'({num_r, 8'h00}) >= {den_r, QUOT_BITS'(0)};

  // SpO2 target 104 - 17R in Q8.8, clamped to 70..100 percent.
  assign m17 = 21'(r_r) * 21'(R_SLOPE);
  always_comb begin
    if (32'(m17) >= SAT_BASE - SAT_MIN) begin
      t_val = SAT_W'(SAT_MIN);
    end else if (32'(m17) <= SAT_BASE - SAT_MAX) begin
      t_val = SAT_W'(SAT_MAX);
    end else begin
      t_val = SAT_W'(21'(SAT_BASE) - m17);
    end
  end

  // The smoothing divisions (by 5, 20 and 10) are prescaled by a shift into
  // avg_arg_r and finished here by a reciprocal multiplication.
  assign q5_prod = QW'(avg_arg_r) * QW'(DIV5_MUL);
  assign q5      = RATE_W'(q5_prod >> DIV5_SHIFT);

  // Operands for the shared divider.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    case (state_r)
      S_HR: begin
        div_start    = count_r != '0;
        div_dividend = DW'(count_r) * DW'(HR_NUM_K);
        div_divisor  = PW'(total_r);
      end
      S_SM: begin
        div_start    = !sat_over;
        div_dividend = {num_r, 8'h00};
        div_divisor  = den_r;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  ppg_hrs_div #(
    .DIVIDEND_W(DW),
    .DIVISOR_W (PW),
    .QUOT_W    (QUOT_BITS)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .done    (div_done),
    .quotient(div_quo)
  );

  // Control and estimator state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      rd_vld_r     <= 1'b0;
      skip_r       <= 4'd0;
      have_last_r  <= 1'b0;
      last_r       <= '0;
      count_r      <= '0;
      total_r      <= '0;
      mode_avg_r   <= 1'b0;
      write_slot_r <= '0;
      filled_r     <= 1'b0;
      rate_shown_r <= '0;
      rate_hist_r  <= RATE_W'(RATE_HIST_RST);
      sat_r        <= SAT_W'(SAT_RST);
      thresh_r     <= SB'(THRESH_RST);
      fin_r        <= 1'b0;
      full_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        thresh_r <= cfg_wr_data;
      end
      // A new result may replace one that leaves in the same cycle.
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      rd_vld_r <= mem_re;
      if (mem_re) begin
        cnt_r <= cnt_r + 1'b1;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            fin_r <= finger;
            cnt_r <= '0;
            if (!finger) begin
              // No finger: drop the window and blank the estimates.
              rate_shown_r <= '0;
              sat_r        <= '0;
              write_slot_r <= '0;
              filled_r     <= 1'b0;
              full_r       <= 1'b0;
              state_r      <= S_OUT;
            end else begin
              write_slot_r <= write_slot_nxt;
              filled_r     <= filled_nxt;
              full_r       <= filled_nxt;
              state_r      <= filled_nxt ? S_P1 : S_OUT;
            end
          end
        end
        S_P1: begin
          if (rd_vld_r && cnt_r == CW'(WINDOW_DEPTH)) begin
            state_r <= S_THR;
          end
        end
        S_THR: begin
          cnt_r       <= '0;
          skip_r      <= 4'd0;
          have_last_r <= 1'b0;
          count_r     <= '0;
          total_r     <= '0;
          state_r     <= S_P2;
        end
        S_P2: begin
          if (is_peak) begin
            if (gap_ok) begin
              total_r <= total_r + CW'(gap);
              count_r <= count_r + 1'b1;
            end
            last_r      <= cand_i;
            have_last_r <= 1'b1;
            skip_r      <= 4'(PEAK_SKIP);
          end else if (cand_en && skip_r != 4'd0) begin
            skip_r <= skip_r - 1'b1;
          end
          if (rd_vld_r && cnt_r == CW'(WINDOW_DEPTH)) begin
            state_r <= S_HR;
          end
        end
        S_HR: begin
          state_r <= (count_r != '0) ? S_HRD : S_SAT;
        end
        S_HRD: begin
          if (div_done) begin
            mode_avg_r <= h_band;
            state_r    <= (h_band || h_high) ? S_RD : S_SAT;
          end
        end
        S_RD: begin
          rate_shown_r <= q5;
          if (mode_avg_r) begin
            rate_hist_r <= q5;
          end
          state_r <= S_SAT;
        end
        S_SAT: begin
          state_r <= sat_ok ? S_SM : S_OUT;
        end
        S_SM: begin
          state_r <= sat_over ? S_ST : S_SD;
        end
        S_SD: begin
          if (div_done) begin
            state_r <= S_ST;
          end
        end
        S_ST: begin
          state_r <= S_SSD;
        end
        S_SSD: begin
          sat_r   <= q5[SAT_W-1:0];
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      imax_r <= '0;
      imin_r <= '1;
      rmax_r <= '0;
      rmin_r <= '1;
    end
    if (state_r == S_P1 && rd_vld_r) begin
      if (rd_ir > imax_r) imax_r <= rd_ir;
      if (rd_ir < imin_r) imin_r <= rd_ir;
      if (rd_red > rmax_r) rmax_r <= rd_red;
      if (rd_red < rmin_r) rmin_r <= rd_red;
    end
    if (state_r == S_THR) begin
      thr10_r <= TW'(imin_r) * TW'(10) + TW'(imax_r - imin_r) * TW'(6);
    end
    if (state_r == S_P2 && rd_vld_r) begin
      v2_r <= v1_r;
      v1_r <= rd_ir;
    end
    if (state_r == S_SAT) begin
      num_r <= PW'(rmax_r - rmin_r) * (PW'(imax_r) + PW'(imin_r));
      den_r <= (PW'(rmax_r) + PW'(rmin_r)) * PW'(imax_r - imin_r);
    end
    if (state_r == S_SM && sat_over) begin
      r_r <= '1;
    end else if (state_r == S_SD && div_done) begin
      r_r <= div_quo;
    end
    // Smoothing numerators: (4*hist + h) / 5, (19*hist + 120 bpm) / 20 as a
    // quarter over 5, and (9*SpO2 + target) / 10 as a half over 5.
    if (state_r == S_HRD && div_done && h_band) begin
      avg_arg_r <= AVG_W'({rate_hist_r, 2'b00}) + AVG_W'(div_quo);
    end else if (state_r == S_HRD && div_done) begin
      avg_arg_r <= AVG_W'((21'(rate_hist_r) * 21'(CAP_MUL) + 21'(CAP_ADD)) >> 2);
    end else if (state_r == S_ST) begin
      avg_arg_r <= AVG_W'((20'(sat_r) * 20'(SAT_MUL) + 20'(t_val)) >> 1);
    end
    if (state_r == S_OUT && out_free) begin
      out_rate_r <= rate_shown_r;
      out_sat_r  <= sat_r;
      out_full_r <= full_r;
      out_fin_r  <= fin_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_heart_rate_q8  = out_rate_r;
  assign out_spo2_q8        = out_sat_r;
  assign out_window_full    = out_full_r;
  assign out_finger_present = out_fin_r;

  `PPG_ASSERT_NEXT(a_no_finger_clears, in_acc && !finger, !filled_r && write_slot_r == '0, "window not cleared")
  `PPG_ASSERT_NEXT(a_full_starts_scan, in_acc && finger && filled_nxt, state_r == S_P1, "scan not started")
  `PPG_ASSERT_IMPL(a_full_has_finger, out_valid, !out_window_full || out_finger_present, "full without finger")
  `PPG_ASSERT_IMPL(a_spo2_bound, out_valid, 32'(out_spo2_q8) <= SAT_MAX, "SpO2 above 100 percent")

endmodule
